// ===== hw/rtl/fjot_pkg.sv =====
// Shared types, character codes and helper functions for the flat JSON object tokenizer.
// Used by fjot_core, fjot_outq and flat_json_object_tokenizer; depends on nothing else.
package fjot_pkg;

    localparam int DEF_MESSAGE_BYTES = 4096;
    localparam int DEF_MAX_DEPTH     = 255;
    localparam logic [7:0] MAX_FIELDS_RESET = 8'd16;

    // Result queue depth: room for two beats from one byte plus slack for back-to-back flow.
    localparam int Q_DEPTH = 4;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LC_E   = 8'h65;
    localparam logic [7:0] CH_UC_E   = 8'h45;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;

    typedef enum logic [3:0] {
        PH_OPEN, PH_FIRST, PH_KEY, PH_KEY_ESC, PH_COLON, PH_VALUE, PH_STR, PH_STR_ESC,
        PH_RAW, PH_RAW_STR, PH_RAW_ESC, PH_LIT, PH_NUM, PH_AFTER, PH_NEXT, PH_DONE
    } t_phase;

    typedef enum logic [1:0] {KIND_FIELD, KIND_OK, KIND_FAIL} t_kind;

    typedef enum logic [2:0] {
        ERR_NONE, ERR_SYNTAX, ERR_TOO_MANY, ERR_INCOMPLETE, ERR_TOO_LONG, ERR_TOO_DEEP
    } t_err;

    typedef enum logic [2:0] {VT_STRING, VT_RAW, VT_BOOL, VT_NULL, VT_NUMBER} t_vtype;

    typedef enum logic [1:0] {LIT_TRUE, LIT_FALSE, LIT_NULL} t_lit;

    typedef struct packed {
        t_kind       kind;
        t_err        err;
        logic [7:0]  field_index;
        logic [11:0] key_offset;
        logic [12:0] key_length;
        t_vtype      vtype;
        logic [11:0] value_offset;
        logic [12:0] value_length;
        logic        bool_value;
        logic        last;
    } t_result;

    // What the parser hands to the result queue for one processed byte.
    typedef struct packed {
        logic [1:0] count;
        t_result    rec0;
        t_result    rec1;
    } t_push;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_num(input logic [7:0] b);
        return is_digit(b) || (b == CH_DOT) || (b == CH_LC_E) || (b == CH_UC_E)
            || (b == CH_PLUS) || (b == CH_MINUS);
    endfunction

    function automatic logic [2:0] lit_len(input t_lit kind);
        logic [2:0] len;
        case (kind)
            LIT_TRUE:  len = 3'd4;
            LIT_FALSE: len = 3'd5;
            LIT_NULL:  len = 3'd4;
            default:   len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] lit_char(input t_lit kind, input logic [2:0] step);
        logic [39:0] txt;
        logic [7:0]  ch;
        case (kind)
            LIT_TRUE:  txt = {8'h74, 8'h72, 8'h75, 8'h65, 8'h00};
            LIT_FALSE: txt = {8'h66, 8'h61, 8'h6C, 8'h73, 8'h65};
            LIT_NULL:  txt = {8'h6E, 8'h75, 8'h6C, 8'h6C, 8'h00};
            default:   txt = '0;
        endcase
        case (step)
            3'd0:    ch = txt[39:32];
            3'd1:    ch = txt[31:24];
            3'd2:    ch = txt[23:16];
            3'd3:    ch = txt[15:8];
            3'd4:    ch = txt[7:0];
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic t_result status_rec(input t_kind kind, input t_err err,
                                           input logic [7:0] count);
        t_result r;
        r             = '0;
        r.kind        = kind;
        r.err         = err;
        r.field_index = count;
        return r;
    endfunction

endpackage

// ===== hw/rtl/flat_json_object_tokenizer.sv =====
// Flat JSON object tokenizer: one message byte per input beat, field records and a status out.
// Each accepted byte is held in an input register and parsed once the result queue has room;
// its result beats are written into the queue and offered from there. Throughput: one byte
// per cycle; input stalls while a byte is held and the result queue holds more than two
// beats. Synchronous active-low reset empties the queue, sets the field limit to 16 and
// puts the parser back to waiting for '{'. Depends on fjot_pkg, fjot_core and fjot_outq.
module flat_json_object_tokenizer
    import fjot_pkg::*;
#(
    parameter int MESSAGE_BYTES = DEF_MESSAGE_BYTES,
    parameter int MAX_DEPTH     = DEF_MAX_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_buffer,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_result_kind,
    output logic [2:0]  o_error_code,
    output logic [7:0]  o_field_index,
    output logic [11:0] o_key_offset,
    output logic [12:0] o_key_length,
    output logic [2:0]  o_value_type,
    output logic [11:0] o_value_offset,
    output logic [12:0] o_value_length,
    output logic        o_bool_value,
    output logic        o_last_of_run
);

    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_eob;
    logic        room;
    logic        fire;
    t_push       push;
    t_result     head;

    // The held beat is parsed once the queue can take both of its possible results.
    assign fire    = r_in_valid && room;
    assign o_ready = !r_in_valid || room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_data_byte;
            r_eob  <= i_end_of_buffer;
        end
    end

    fjot_core #(
        .MESSAGE_BYTES (MESSAGE_BYTES),
        .MAX_DEPTH     (MAX_DEPTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_fire     (fire),
        .i_byte     (r_byte),
        .i_eob      (r_eob),
        .o_push     (push)
    );

    fjot_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rec   (head)
    );

    assign o_result_kind  = head.kind;
    assign o_error_code   = head.err;
    assign o_field_index  = head.field_index;
    assign o_key_offset   = head.key_offset;
    assign o_key_length   = head.key_length;
    assign o_value_type   = head.vtype;
    assign o_value_offset = head.value_offset;
    assign o_value_length = head.value_length;
    assign o_bool_value   = head.bool_value;
    assign o_last_of_run  = head.last;

endmodule

// ===== hw/rtl/fjot_outq.sv =====
// Small result queue between the parser and the output channel.
// Takes up to two beats per cycle, gives one; depends on fjot_pkg.
module fjot_outq
    import fjot_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_push       i_push,
    output logic        o_room,
    output logic        o_valid,
    input  logic        i_ready,
    output t_result     o_rec
);

    localparam int QA_W = $clog2(Q_DEPTH);
    localparam int QC_W = $clog2(Q_DEPTH + 1);

    t_result           r_mem [Q_DEPTH];
    logic [QA_W-1:0]   r_wr;
    logic [QA_W-1:0]   r_rd;
    logic [QC_W-1:0]   r_cnt;
    logic [QA_W-1:0]   wr_next;
    logic              pop;

    assign wr_next = r_wr + QA_W'(1);
    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rd];
    // Room is judged without the pop of this cycle, which keeps this path short.
    assign o_room  = (r_cnt <= QC_W'(Q_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.rec0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.rec1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + QA_W'(i_push.count);
            r_cnt <= r_cnt + QC_W'(i_push.count) - QC_W'(pop);
            if (pop) begin
                r_rd <= r_rd + QA_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QC_W'(Q_DEPTH))
        else $error("result queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> (r_cnt <= QC_W'(Q_DEPTH - 2)))
        else $error("push into result queue without room");

    a_pair_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count == 2'd2 && !pop) |=> (r_cnt == $past(r_cnt) + QC_W'(2)))
        else $error("double push not counted");
`endif

endmodule

// ===== hw/rtl/fjot_core.sv =====
// Parser state and per-byte step logic: one registered byte in, up to two result beats out.
// Holds the field-limit register; depends on fjot_pkg.
module fjot_core
    import fjot_pkg::*;
#(
    parameter int MESSAGE_BYTES = DEF_MESSAGE_BYTES,
    parameter int MAX_DEPTH     = DEF_MAX_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_fire,
    input  logic [7:0]  i_byte,
    input  logic        i_eob,
    output t_push       o_push
);

    localparam int POS_W = $clog2(MESSAGE_BYTES + 1);
    localparam int DEP_W = $clog2(MAX_DEPTH + 1);
    localparam int EXT_W = (POS_W > 13) ? POS_W : 13;

    t_phase            r_phase,     n_phase;
    logic [POS_W-1:0]  r_pos,       n_pos;
    logic [DEP_W-1:0]  r_depth,     n_depth;
    logic [2:0]        r_lit_step,  n_lit_step;
    t_lit              r_lit_kind,  n_lit_kind;
    logic [7:0]        r_count,     n_count;
    logic [POS_W-1:0]  r_koff,      n_koff;
    logic [12:0]       r_klen,      n_klen;
    logic [POS_W-1:0]  r_voff,      n_voff;
    t_vtype            r_vtype,     n_vtype;
    logic [7:0]        r_max_fields;

    logic [EXT_W-1:0]  pos_x, koff_x, voff_x;
    logic [EXT_W-1:0]  len_incl, len_excl, klen_x;
    logic [DEP_W-1:0]  depth_dec;
    logic [2:0]        lit_next;

    logic              a_v, b_v, c_v;
    t_result           a_rec, b_rec, c_rec;
    logic              fin_req, fin_bv, num_end;
    logic [12:0]       fin_len;
    t_result           fin_rec;

    // Byte after a value: white space, a comma or the closing brace.
    logic              av_status;
    t_kind             av_kind;
    t_err              av_err;
    t_phase            av_phase;

    assign pos_x     = EXT_W'(r_pos);
    assign koff_x    = EXT_W'(r_koff);
    assign voff_x    = EXT_W'(r_voff);
    assign len_incl  = pos_x + EXT_W'(1) - voff_x;
    assign len_excl  = pos_x - voff_x;
    assign klen_x    = pos_x - koff_x;
    assign depth_dec = (r_depth != '0) ? (r_depth - DEP_W'(1)) : '0;
    assign lit_next  = r_lit_step + 3'd1;

    always_comb begin
        av_status = 1'b0;
        av_kind   = KIND_OK;
        av_err    = ERR_NONE;
        av_phase  = PH_AFTER;
        if (i_byte == CH_COMMA) begin
            av_phase = PH_NEXT;
        end else if (i_byte == CH_RBRACE) begin
            av_status = 1'b1;
            av_phase  = PH_DONE;
        end else if (!is_space(i_byte)) begin
            av_status = 1'b1;
            av_kind   = KIND_FAIL;
            av_err    = ERR_SYNTAX;
            av_phase  = PH_DONE;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_depth    = r_depth;
        n_lit_step = r_lit_step;
        n_lit_kind = r_lit_kind;
        n_count    = r_count;
        n_koff     = r_koff;
        n_klen     = r_klen;
        n_voff     = r_voff;
        n_vtype    = r_vtype;
        a_v        = 1'b0;
        b_v        = 1'b0;
        c_v        = 1'b0;
        a_rec      = '0;
        b_rec      = '0;
        c_rec      = '0;
        fin_req    = 1'b0;
        fin_bv     = 1'b0;
        fin_len    = '0;
        num_end    = 1'b0;
        fin_rec    = '0;

        if (r_phase == PH_DONE) begin
            // Bytes after a status are dropped until the end of the buffer.
        end else if (r_pos >= POS_W'(MESSAGE_BYTES)) begin
            a_v     = 1'b1;
            a_rec   = status_rec(KIND_FAIL, ERR_TOO_LONG, r_count);
            n_phase = PH_DONE;
        end else begin
            unique case (r_phase) inside
                PH_OPEN: begin
                    if (i_byte == CH_LBRACE) begin
                        n_phase = PH_FIRST;
                    end else if (!is_space(i_byte)) begin
                        a_v     = 1'b1;
                        a_rec   = status_rec(KIND_FAIL, ERR_SYNTAX, r_count);
                        n_phase = PH_DONE;
                    end
                end
                PH_FIRST, PH_NEXT: begin
                    if (i_byte == CH_QUOTE) begin
                        n_koff  = r_pos + POS_W'(1);
                        n_phase = PH_KEY;
                    end else if (i_byte == CH_RBRACE && r_phase == PH_FIRST) begin
                        a_v     = 1'b1;
                        a_rec   = status_rec(KIND_OK, ERR_NONE, r_count);
                        n_phase = PH_DONE;
                    end else if (!is_space(i_byte)) begin
                        a_v     = 1'b1;
                        a_rec   = status_rec(KIND_FAIL, ERR_SYNTAX, r_count);
                        n_phase = PH_DONE;
                    end
                end
                PH_KEY: begin
                    if (i_byte == CH_BSLASH) begin
                        n_phase = PH_KEY_ESC;
                    end else if (i_byte == CH_QUOTE) begin
                        n_klen  = klen_x[12:0];
                        n_phase = PH_COLON;
                    end
                end
                PH_KEY_ESC: begin
                    n_phase = PH_KEY;
                end
                PH_COLON: begin
                    if (i_byte == CH_COLON) begin
                        n_phase = PH_VALUE;
                    end else if (!is_space(i_byte)) begin
                        a_v     = 1'b1;
                        a_rec   = status_rec(KIND_FAIL, ERR_SYNTAX, r_count);
                        n_phase = PH_DONE;
                    end
                end
                PH_VALUE: begin
                    if (!is_space(i_byte)) begin
                        n_voff = r_pos;
                        if (i_byte == CH_QUOTE) begin
                            n_vtype = VT_STRING;
                            n_phase = PH_STR;
                        end else if (i_byte == CH_LBRACK || i_byte == CH_LBRACE) begin
                            n_vtype = VT_RAW;
                            n_depth = DEP_W'(1);
                            n_phase = PH_RAW;
                        end else if (i_byte == CH_LC_T || i_byte == CH_LC_F
                                     || i_byte == CH_LC_N) begin
                            if (i_byte == CH_LC_T) begin
                                n_lit_kind = LIT_TRUE;
                            end else if (i_byte == CH_LC_F) begin
                                n_lit_kind = LIT_FALSE;
                            end else begin
                                n_lit_kind = LIT_NULL;
                            end
                            n_vtype    = (i_byte == CH_LC_N) ? VT_NULL : VT_BOOL;
                            n_lit_step = 3'd1;
                            n_phase    = PH_LIT;
                        end else if (i_byte == CH_MINUS || is_digit(i_byte)) begin
                            n_vtype = VT_NUMBER;
                            n_phase = PH_NUM;
                        end else begin
                            a_v     = 1'b1;
                            a_rec   = status_rec(KIND_FAIL, ERR_SYNTAX, r_count);
                            n_phase = PH_DONE;
                        end
                    end
                end
                PH_STR: begin
                    if (i_byte == CH_BSLASH) begin
                        n_phase = PH_STR_ESC;
                    end else if (i_byte == CH_QUOTE) begin
                        fin_req = 1'b1;
                        fin_len = len_incl[12:0];
                    end
                end
                PH_STR_ESC: begin
                    n_phase = PH_STR;
                end
                PH_RAW: begin
                    if (i_byte == CH_QUOTE) begin
                        n_phase = PH_RAW_STR;
                    end else if (i_byte == CH_LBRACK || i_byte == CH_LBRACE) begin
                        if (r_depth >= DEP_W'(MAX_DEPTH)) begin
                            a_v     = 1'b1;
                            a_rec   = status_rec(KIND_FAIL, ERR_TOO_DEEP, r_count);
                            n_phase = PH_DONE;
                        end else begin
                            n_depth = r_depth + DEP_W'(1);
                        end
                    end else if (i_byte == CH_RBRACK || i_byte == CH_RBRACE) begin
                        n_depth = depth_dec;
                        if (depth_dec == '0) begin
                            fin_req = 1'b1;
                            fin_len = len_incl[12:0];
                        end
                    end
                end
                PH_RAW_STR: begin
                    if (i_byte == CH_BSLASH) begin
                        n_phase = PH_RAW_ESC;
                    end else if (i_byte == CH_QUOTE) begin
                        n_phase = PH_RAW;
                    end
                end
                PH_RAW_ESC: begin
                    n_phase = PH_RAW_STR;
                end
                PH_LIT: begin
                    if (r_lit_step >= lit_len(r_lit_kind)
                        || i_byte != lit_char(r_lit_kind, r_lit_step)) begin
                        a_v     = 1'b1;
                        a_rec   = status_rec(KIND_FAIL, ERR_SYNTAX, r_count);
                        n_phase = PH_DONE;
                    end else begin
                        n_lit_step = lit_next;
                        if (lit_next == lit_len(r_lit_kind)) begin
                            fin_req = 1'b1;
                            fin_len = 13'(lit_len(r_lit_kind));
                            fin_bv  = (r_lit_kind == LIT_TRUE);
                        end
                    end
                end
                PH_NUM: begin
                    // The byte that ends a number is then taken as the byte after a value.
                    if (!is_num(i_byte)) begin
                        fin_req = 1'b1;
                        fin_len = len_excl[12:0];
                        num_end = 1'b1;
                    end
                end
                PH_AFTER: begin
                    n_phase = av_phase;
                    if (av_status) begin
                        a_v   = 1'b1;
                        a_rec = status_rec(av_kind, av_err, r_count);
                    end
                end
                default: begin
                    a_v     = 1'b1;
                    a_rec   = status_rec(KIND_FAIL, ERR_SYNTAX, r_count);
                    n_phase = PH_DONE;
                end
            endcase
        end

        if (fin_req) begin
            if (r_count >= r_max_fields) begin
                a_v     = 1'b1;
                a_rec   = status_rec(KIND_FAIL, ERR_TOO_MANY, r_count);
                n_phase = PH_DONE;
            end else begin
                fin_rec.kind         = KIND_FIELD;
                fin_rec.err          = ERR_NONE;
                fin_rec.field_index  = r_count;
                fin_rec.key_offset   = koff_x[11:0];
                fin_rec.key_length   = r_klen;
                fin_rec.vtype        = r_vtype;
                fin_rec.value_offset = voff_x[11:0];
                fin_rec.value_length = fin_len;
                fin_rec.bool_value   = fin_bv;
                a_v     = 1'b1;
                a_rec   = fin_rec;
                n_count = r_count + 8'd1;
                n_phase = PH_AFTER;
                if (num_end) begin
                    n_phase = av_phase;
                    if (av_status) begin
                        b_v   = 1'b1;
                        b_rec = status_rec(av_kind, av_err, n_count);
                    end
                end
            end
        end

        if (i_eob) begin
            if (n_phase != PH_DONE) begin
                c_v   = 1'b1;
                c_rec = status_rec(KIND_FAIL, ERR_INCOMPLETE, n_count);
            end
            n_phase    = PH_OPEN;
            n_pos      = '0;
            n_depth    = '0;
            n_lit_step = '0;
            n_count    = '0;
        end else if (r_pos < POS_W'(MESSAGE_BYTES)) begin
            n_pos = r_pos + POS_W'(1);
        end

        // A second beat only ever follows a first one from the same byte.
        o_push.count     = i_fire ? (2'(a_v) + 2'(b_v) + 2'(c_v)) : 2'd0;
        o_push.rec0      = a_v ? a_rec : c_rec;
        o_push.rec1      = b_v ? b_rec : c_rec;
        o_push.rec0.last = (2'(a_v) + 2'(b_v) + 2'(c_v)) == 2'd1;
        o_push.rec1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_fields <= MAX_FIELDS_RESET;
        end else if (i_cfg_we) begin
            r_max_fields <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_OPEN;
            r_pos      <= '0;
            r_depth    <= '0;
            r_lit_step <= '0;
            r_lit_kind <= LIT_TRUE;
            r_count    <= '0;
            r_koff     <= '0;
            r_klen     <= '0;
            r_voff     <= '0;
            r_vtype    <= VT_STRING;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_depth    <= n_depth;
            r_lit_step <= n_lit_step;
            r_lit_kind <= n_lit_kind;
            r_count    <= n_count;
            r_koff     <= n_koff;
            r_klen     <= n_klen;
            r_voff     <= n_voff;
            r_vtype    <= n_vtype;
        end
    end

`ifndef SYNTHESIS
    a_field_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count != 2'd0 && o_push.rec0.kind == KIND_FIELD)
            |-> (o_push.rec0.field_index < r_max_fields))
        else $error("field record beyond the field limit");

    a_eob_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_eob) |=> (r_phase == PH_OPEN && r_pos == '0 && r_count == '0))
        else $error("parser not restarted after end of buffer");

    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_phase == PH_DONE && !i_eob) |-> (o_push.count == 2'd0))
        else $error("result produced after final status");
`endif

endmodule
